/* hw/rtl/pti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase table inverse interpolator package
// Sizes, codes, state encoding and the divider request/response types.
// ----------------------------------------------------------------------------
package pti_pkg;

	localparam int TABLE_SIZE = 360;

	localparam int SAMPLE_W = 16;
	localparam int ENTRY_W  = SAMPLE_W + 1;
	localparam int TARGET_W = 9;
	localparam int POS_W    = 19;
	localparam int PHASE_FRAC_W = 6;
	localparam int FRAC_W   = 10;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);

	localparam int TFIX_W = TARGET_W + PHASE_FRAC_W;
	localparam int CMP_W  = ENTRY_W + 2;

	localparam int NUM_W  = ENTRY_W;
	localparam int DEN_W  = ENTRY_W;
	localparam int DVD_W  = NUM_W + FRAC_W;
	localparam int QUO_W  = DVD_W;
	localparam int STEP_W = $clog2(DVD_W);
	localparam int SUM_W  = QUO_W + 1;

	localparam int POS_MAX         = (1 << POS_W) - 1;
	localparam int FULL_CIRCLE_FIX = 360 << PHASE_FRAC_W;
	localparam int END_POS_FULL    = TABLE_SIZE << FRAC_W;
	localparam logic [POS_W-1:0] END_POS =
		POS_W'((END_POS_FULL > POS_MAX) ? POS_MAX : END_POS_FULL);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic STAT_OK      = 1'b0;
	localparam logic STAT_PARTIAL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIVIDE,
		ST_POST
	} pti_state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* hw/rtl/pti_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase table inverse interpolator channels
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pti_in_if;
	import pti_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic signed [SAMPLE_W-1:0] sample;
	logic [TARGET_W-1:0]        target;

	modport source (output valid, cmd, sample, target, input ready);
	modport sink (input valid, cmd, sample, target, output ready);
endinterface

interface pti_out_if;
	import pti_pkg::*;

	logic                valid;
	logic                ready;
	logic [TARGET_W-1:0] target_echo;
	logic [POS_W-1:0]    position;
	logic                status;

	modport source (output valid, target_echo, position, status, input ready);
	modport sink (input valid, target_echo, position, status, output ready);
endinterface

/* hw/rtl/phase_table_inverse_interpolator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase table inverse interpolator
// Stores a phase table and inverts it by piecewise linear interpolation.
// ----------------------------------------------------------------------------
// Load beat: writes one table entry, no result.
// Query on a full table: the one-entry-per-cycle table scan through the RAM
// read port, then the bit-serial divider where needed. Query on a partial
// table: no scan and no division, status partial.
// One item at a time; a new item is taken while a result waits in the output.
// Reset clears the load count and first sample; table contents stay undefined.
module phase_table_inverse_interpolator_core (
	input  logic      clk,
	input  logic      arst_n,
	pti_in_if.sink    item,
	pti_out_if.source result
);
	import pti_pkg::*;

	pti_state_t state_q, state_d;

	logic [CNT_W-1:0]           cnt_q;
	logic signed [SAMPLE_W-1:0] first_q;
	logic [TFIX_W-1:0]          tf_q;
	logic [TARGET_W-1:0]        echo_q;
	logic [IDX_W-1:0]           rd_idx_q;
	logic                       issue_q;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic                       rd_vld_s1;
	logic signed [ENTRY_W-1:0]  prev_q;
	logic [IDX_W-1:0]           seg_q;
	logic [POS_W-1:0]           pos_q;
	logic                       stat_q;

	logic                out_vld_q;
	logic [TARGET_W-1:0] out_echo_q;
	logic [POS_W-1:0]    out_pos_q;
	logic                out_stat_q;

	logic                in_fire;
	logic                full;
	logic                wr_first;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [ENTRY_W-1:0]  wdata;
	logic                re;
	logic [ENTRY_W-1:0]  rdata;

	logic signed [CMP_W-1:0] ent_x, prev_x, tf_x, lden, sdiff, ddiff;
	logic                    eval, first_ent, gt, last_ent;
	logic                    found, end_flat, div_go, keep_prev;
	logic [NUM_W-1:0]        num_d;
	logic [DEN_W-1:0]        den_d;
	logic [IDX_W-1:0]        seg_d;
	logic                    post_go;
	logic [SUM_W-1:0]        sum;
	logic [POS_W-1:0]        sat_pos;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// load path
	assign in_fire    = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign full       = (cnt_q == CNT_W'(TABLE_SIZE));
	assign wr_first   = full || (cnt_q == '0);
	assign waddr      = full ? '0 : cnt_q[IDX_W-1:0];
	assign wdata      = wr_first ? '0 :
		({item.sample[SAMPLE_W-1], item.sample} - {first_q[SAMPLE_W-1], first_q});
	assign we         = in_fire && (item.cmd == CMD_LOAD);
	assign re         = (state_q == ST_SCAN) && issue_q;

	pti_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	// scan decode
	always_comb begin
		ent_x     = {{(CMP_W-ENTRY_W){rdata[ENTRY_W-1]}}, rdata};
		prev_x    = {{(CMP_W-ENTRY_W){prev_q[ENTRY_W-1]}}, prev_q};
		tf_x      = {{(CMP_W-TFIX_W){1'b0}}, tf_q};
		lden      = CMP_W'(FULL_CIRCLE_FIX) - ent_x;
		sdiff     = tf_x - prev_x;
		ddiff     = ent_x - prev_x;
		eval      = (state_q == ST_SCAN) && rd_vld_s1;
		first_ent = (rd_idx_s1 == '0);
		last_ent  = (rd_idx_s1 == IDX_W'(TABLE_SIZE - 1));
		gt        = ent_x > tf_x;
		found     = eval && !first_ent && gt;
		end_flat  = eval && !first_ent && !gt && last_ent
			&& (lden[CMP_W-1] || lden == '0);
		div_go    = found || (eval && !first_ent && !gt && last_ent && !end_flat);
		keep_prev = eval && !found && !div_go;
		if (found) begin
			num_d = sdiff[NUM_W-1:0];
			den_d = ddiff[DEN_W-1:0];
			seg_d = rd_idx_s1 - 1'b1;
		end else begin
			num_d = NUM_W'(tf_x - ent_x);
			den_d = lden[DEN_W-1:0];
			seg_d = IDX_W'(TABLE_SIZE - 1);
		end
		div_req.start    = div_go;
		div_req.dividend = {num_d, {FRAC_W{1'b0}}};
		div_req.divisor  = den_d;
		sum     = (SUM_W'(seg_q) << FRAC_W) + SUM_W'(div_rsp.quotient);
		sat_pos = (sum > SUM_W'(POS_MAX)) ? POS_W'(POS_MAX) : sum[POS_W-1:0];
		post_go = (state_q == ST_POST) && (!out_vld_q || result.ready);
	end

	pti_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && item.cmd == CMD_QUERY) begin
					state_d = full ? ST_SCAN : ST_POST;
				end
			end
			ST_SCAN: begin
				if (div_go) begin
					state_d = ST_DIVIDE;
				end else if (end_flat) begin
					state_d = ST_POST;
				end
			end
			ST_DIVIDE: begin
				if (div_rsp.done) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (post_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			first_q   <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= re;
			if (we) begin
				cnt_q <= CNT_W'(waddr) + 1'b1;
				if (wr_first) begin
					first_q <= item.sample;
				end
			end
			if (in_fire && item.cmd == CMD_QUERY) begin
				issue_q <= 1'b1;
			end else if (re && rd_idx_q == IDX_W'(TABLE_SIZE - 1)) begin
				issue_q <= 1'b0;
			end
			if (post_go) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		if (in_fire && item.cmd == CMD_QUERY) begin
			tf_q     <= {item.target, {PHASE_FRAC_W{1'b0}}};
			echo_q   <= item.target;
			rd_idx_q <= '0;
			pos_q    <= '0;
			stat_q   <= full ? STAT_OK : STAT_PARTIAL;
		end else if (re) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (eval && first_ent) begin
			prev_q <= rdata;
		end else if (keep_prev) begin
			prev_q <= rdata;
		end
		if (div_go) begin
			seg_q <= seg_d;
		end
		if (end_flat) begin
			pos_q <= END_POS;
		end else if (state_q == ST_DIVIDE && div_rsp.done) begin
			pos_q <= sat_pos;
		end
		if (post_go) begin
			out_echo_q <= echo_q;
			out_pos_q  <= pos_q;
			out_stat_q <= stat_q;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.target_echo = out_echo_q;
	assign result.position    = out_pos_q;
	assign result.status      = out_stat_q;

endmodule

/* hw/rtl/pti_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/pti_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase table inverse interpolator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pti_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pti_pkg::div_req_t req,
	output pti_pkg::div_rsp_t rsp
);
	import pti_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DVD_W-1:0]  quo_q;

	logic [DEN_W:0]    shifted;
	logic              ge;
	logic [DEN_W:0]    rem_n;

	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		ge      = shifted >= {1'b0, den_q};
		rem_n   = ge ? (shifted - {1'b0, den_q}) : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= req.divisor;
			quo_q  <= req.dividend;
			step_q <= STEP_W'(DVD_W - 1);
		end else if (busy_q) begin
			rem_q  <= rem_n[DEN_W-1:0];
			quo_q  <= {quo_q[DVD_W-2:0], ge};
			step_q <= step_q - 1'b1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase table inverse interpolator testbench
// Loads phase tables with random content, queries the inverse on partial and
// full tables, and checks every answer against a built-in predictor while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import pti_pkg::*;

	typedef struct {
		logic                       cmd;
		logic signed [SAMPLE_W-1:0] sample;
		logic [TARGET_W-1:0]        target;
	} beat_t;

	typedef struct {
		logic [TARGET_W-1:0] target_echo;
		logic [POS_W-1:0]    position;
		logic                status;
	} answer_t;

	typedef enum {TBL_NOISE, TBL_RAMP} table_kind_t;

	logic clk;
	logic arst_n;

	pti_in_if  item_ch();
	pti_out_if result_ch();

	phase_table_inverse_interpolator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	beat_t   beats_to_send[$];
	answer_t pending_answers[$];

	logic signed [ENTRY_W-1:0]  phase_tab [TABLE_SIZE];
	logic signed [SAMPLE_W-1:0] first_sample;
	int                         loaded;
	int                         planned_count;

	int total_items;
	int accepted_count;
	int answers_seen;
	int error_count;

	int          burst_left;
	int          gap_left;
	logic [15:0] rx_tick;
	int          hold_left;
	logic        hold_done;

	function automatic logic [POS_W-1:0] clamp_pos(longint p);
		if (p < 0)
			return '0;
		if (p > POS_MAX)
			return POS_MAX[POS_W-1:0];
		return p[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] invert_phase(logic [TARGET_W-1:0] tgt);
		longint tf;
		longint lo;
		longint hi;
		longint last;
		longint den;
		tf = longint'(tgt) * (1 << PHASE_FRAC_W);
		for (int j = 1; j < TABLE_SIZE; j++) begin
			hi = phase_tab[j];
			if (hi > tf) begin
				lo = phase_tab[j-1];
				return clamp_pos(longint'(j - 1) * (1 << FRAC_W) +
					((tf - lo) * (1 << FRAC_W)) / (hi - lo));
			end
		end
		last = phase_tab[TABLE_SIZE-1];
		den = longint'(FULL_CIRCLE_FIX) - last;
		if (den <= 0)
			return clamp_pos(longint'(TABLE_SIZE) * (1 << FRAC_W));
		return clamp_pos(longint'(TABLE_SIZE - 1) * (1 << FRAC_W) +
			((tf - last) * (1 << FRAC_W)) / den);
	endfunction

	task automatic track_item(logic cmd, logic signed [SAMPLE_W-1:0] smp,
		logic [TARGET_W-1:0] tgt);
		answer_t ans;
		int      diff;
		if (cmd == CMD_LOAD) begin
			if (loaded >= TABLE_SIZE)
				loaded = 0;
			if (loaded == 0)
				first_sample = smp;
			diff = int'(smp) - int'(first_sample);
			phase_tab[loaded] = diff[ENTRY_W-1:0];
			loaded++;
		end else begin
			ans.target_echo = tgt;
			ans.status = (loaded < TABLE_SIZE) ? STAT_PARTIAL : STAT_OK;
			ans.position = (ans.status == STAT_OK) ? invert_phase(tgt) : '0;
			pending_answers.push_back(ans);
		end
	endtask

	task automatic push_load(int smp);
		beat_t b;
		b.cmd = CMD_LOAD;
		b.sample = smp[SAMPLE_W-1:0];
		b.target = '0;
		beats_to_send.push_back(b);
		if (planned_count >= TABLE_SIZE)
			planned_count = 0;
		planned_count++;
	endtask

	task automatic push_query(int tgt);
		beat_t b;
		b.cmd = CMD_QUERY;
		b.sample = SAMPLE_W'($urandom);
		b.target = tgt[TARGET_W-1:0];
		beats_to_send.push_back(b);
	endtask

	function automatic int pick_target();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(0, 359);
		if (r < 9)
			return $urandom_range(360, 511);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 359;
			2: return 360;
			default: return 511;
		endcase
	endfunction

	// Fill the table up to full; a stray query now and then sees a partial table.
	task automatic push_table(table_kind_t kind, int span);
		int idx;
		int val;
		int base;
		base = 0;
		do begin
			idx = (planned_count >= TABLE_SIZE) ? 0 : planned_count;
			if (idx == 0)
				base = $urandom_range(0, 65535 - span - 32) - 32768 + 16;
			if (kind == TBL_RAMP) begin
				val = base + (idx * span) / (TABLE_SIZE - 1);
				if (idx != 0 && $urandom_range(0, 1))
					val += $urandom_range(0, 32) - 16;
			end else begin
				case ($urandom_range(0, 3))
					0: val = -32768;
					1: val = 32767;
					default: val = $urandom;
				endcase
			end
			if (idx > 0 && $urandom_range(0, 24) == 0)
				push_query(pick_target());
			push_load(val);
		end while (planned_count < TABLE_SIZE);
	endtask

	task automatic push_query_batch(int n);
		for (int i = 0; i < n; i++)
			push_query(pick_target());
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		beat_t b;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			burst_left <= $urandom_range(1, 40);
			gap_left <= 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				track_item(item_ch.cmd, item_ch.sample, item_ch.target);
				accepted_count++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					item_ch.valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					b = beats_to_send.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.cmd <= b.cmd;
					item_ch.sample <= b.sample;
					item_ch.target <= b.target;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Hold off once for a long stretch so the core backs up into its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_tick <= '0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 1'b1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (!hold_done && answers_seen >= 20) begin
				hold_done <= 1'b1;
				hold_left <= 2000;
				result_ch.ready <= 1'b0;
			end else begin
				case (rx_tick[8:7])
					2'd0: result_ch.ready <= 1'b1;
					2'd1: result_ch.ready <= (rx_tick % 3 == 0);
					2'd2: result_ch.ready <= $urandom_range(0, 1);
					default: result_ch.ready <= (rx_tick[3:0] > 4'd10);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected beat: target_echo %0d position %0d status %0d",
					$realtime, result_ch.target_echo, result_ch.position, result_ch.status);
				error_count++;
			end else begin
				want = pending_answers.pop_front();
				if (result_ch.target_echo !== want.target_echo) begin
					$display("%0t: target_echo expected %0d actual %0d",
						$realtime, want.target_echo, result_ch.target_echo);
					error_count++;
				end
				if (result_ch.position !== want.position) begin
					$display("%0t: position (target %0d) expected %0d actual %0d",
						$realtime, want.target_echo, want.position, result_ch.position);
					error_count++;
				end
				if (result_ch.status !== want.status) begin
					$display("%0t: status (target %0d) expected %0d actual %0d",
						$realtime, want.target_echo, want.status, result_ch.status);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_LOAD;
		item_ch.sample = '0;
		item_ch.target = '0;
		result_ch.ready = 1'b0;
		loaded = 0;
		first_sample = '0;
		planned_count = 0;
		accepted_count = 0;
		answers_seen = 0;
		error_count = 0;

		push_query(0);
		push_query(511);
		push_query(359);
		push_query(256);
		push_load(32767);
		push_load(-32768);
		push_load(0);
		push_load(1);
		push_load(-1);
		push_load(21845);
		push_load(-21846);
		push_query(360);
		push_query(1);
		push_query(170);
		push_query(341);

		push_table(TBL_NOISE, 0);
		push_query_batch(50);
		push_table(TBL_RAMP, $urandom_range(0, 1) ? 22976 : $urandom_range(22900, 23039));
		push_query_batch(50);
		total_items = beats_to_send.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (accepted_count == total_items);
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (TABLE_SIZE + 40) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
